@@ hw/rtl/three_point_circumcenter_unit_macros.svh @@
// assertion macros for the circumcenter unit checker
// used by cc_checker.sv, relies on clk_i and rst_ni in the including scope
`ifndef THREE_POINT_CIRCUMCENTER_UNIT_MACROS_SVH
`define THREE_POINT_CIRCUMCENTER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define CC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("circumcenter unit check failed");

// next-cycle implication, off during reset
`define CC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("circumcenter unit check failed");

// reset behaviour, always live
`define CC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk_i) !rst_ni |=> (cons)) \
    else $error("circumcenter unit reset check failed");

`endif

@@ hw/rtl/cc_pkg.sv @@
// shared types and constants of the circumcenter unit
// no dependencies
`timescale 1ns / 1ps

package cc_pkg;

  // quotient bits resolved by the divider, one per stage
  localparam int unsigned QBITS = 32;

  localparam logic [QBITS-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [QBITS-1:0] NEG_MAX = 32'h8000_0000;

  // per item control flags carried down the divider
  typedef struct packed {
    logic zero;
    logic neg_x;
    logic neg_y;
    logic big_x;
    logic big_y;
  } flags_t;

endpackage

@@ hw/rtl/cc_ifs.sv @@
// valid/ready channel interfaces for point triples and circle centres
// no dependencies
`timescale 1ns / 1ps

interface cc_pts_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;

  modport source (output valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  input ready);
  modport sink   (input valid, first_x, first_y, second_x, second_y, third_x, third_y,
                  output ready);
endinterface

interface cc_ctr_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic               degenerate;

  modport source (output valid, center_x, center_y, degenerate, input ready);
  modport sink   (input valid, center_x, center_y, degenerate, output ready);
endinterface

@@ hw/rtl/cc_front.sv @@
// front stages: edge vectors, determinant, numerators, magnitudes, divider setup
// depends on cc_pkg
`timescale 1ns / 1ps

module cc_front #(
  parameter int unsigned CW = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [CW-1:0]    x1_i,
  input  logic signed [CW-1:0]    y1_i,
  input  logic signed [CW-1:0]    x2_i,
  input  logic signed [CW-1:0]    y2_i,
  input  logic signed [CW-1:0]    x3_i,
  input  logic signed [CW-1:0]    y3_i,
  output logic [2*CW+2:0]         d_o,
  output logic [2*CW+2:0]         rem_x_o,
  output logic [2*CW+2:0]         rem_y_o,
  output logic [cc_pkg::QBITS-1:0] nq_x_o,
  output logic [cc_pkg::QBITS-1:0] nq_y_o,
  output cc_pkg::flags_t          flags_o
);
  localparam int unsigned DW = 2 * CW + 3;
  localparam int unsigned NW = 3 * CW + 4;
  localparam int unsigned QB = cc_pkg::QBITS;

  // stage 1: edge vectors
  logic signed [CW:0]   ax_q, ay_q, bx_q, by_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q <= {x2_i[CW-1], x2_i} - {x1_i[CW-1], x1_i};
      ay_q <= {y2_i[CW-1], y2_i} - {y1_i[CW-1], y1_i};
      bx_q <= {x3_i[CW-1], x3_i} - {x2_i[CW-1], x2_i};
      by_q <= {y3_i[CW-1], y3_i} - {y2_i[CW-1], y2_i};
      x1_q <= x1_i;
      y1_q <= y1_i;
      x2_q <= x2_i;
      y2_q <= y2_i;
      x3_q <= x3_i;
      y3_q <= y3_i;
    end
  end

  // stage 2: cross products and squares
  logic signed [2*CW+1:0] p1_q, p2_q;
  logic signed [2*CW:0]   sx1_q, sy1_q, sx2_q, sy2_q, sx3_q, sy3_q;
  logic signed [CW:0]     ax2_q, ay2_q, bx2_q, by2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q  <= ax_q * by_q;
      p2_q  <= ay_q * bx_q;
      sx1_q <= x1_q * x1_q;
      sy1_q <= y1_q * y1_q;
      sx2_q <= x2_q * x2_q;
      sy2_q <= y2_q * y2_q;
      sx3_q <= x3_q * x3_q;
      sy3_q <= y3_q * y3_q;
      ax2_q <= ax_q;
      ay2_q <= ay_q;
      bx2_q <= bx_q;
      by2_q <= by_q;
    end
  end

  // stage 3: determinant and squared norm differences
  logic signed [2*CW+2:0] det3_q;
  logic signed [2*CW+1:0] s21_q, s32_q;
  logic signed [CW:0]     ax3_q, ay3_q, bx3_q, by3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      det3_q <= p1_q - p2_q;
      s21_q  <= (sx2_q + sy2_q) - (sx1_q + sy1_q);
      s32_q  <= (sx3_q + sy3_q) - (sx2_q + sy2_q);
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
      bx3_q  <= bx2_q;
      by3_q  <= by2_q;
    end
  end

  // stage 4: numerator partial products
  logic signed [NW-1:0]   m1_q, m2_q, m3_q, m4_q;
  logic signed [2*CW+2:0] det4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q   <= s21_q * by3_q;
      m2_q   <= s32_q * ay3_q;
      m3_q   <= s32_q * ax3_q;
      m4_q   <= s21_q * bx3_q;
      det4_q <= det3_q;
    end
  end

  // stage 5: numerators, divisor magnitude
  logic signed [2*CW+3:0] det2;
  logic [2*CW+3:0]        dabs;
  logic signed [NW-1:0]   nx_q, ny_q;
  logic [DW-1:0]          d5_q;
  logic                   dneg_q, zero_q;

  assign det2 = {det4_q, 1'b0};
  assign dabs = det2[2*CW+3] ? -det2 : det2;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nx_q   <= m1_q - m2_q;
      ny_q   <= m3_q - m4_q;
      d5_q   <= dabs[DW-1:0];
      dneg_q <= det4_q[2*CW+2];
      zero_q <= (det4_q == '0);
    end
  end

  // stage 6: numerator magnitudes, overflow check, initial remainder
  logic [NW-1:0]    magx, magy, dext;
  logic [NW+QB-1:0] extx, exty;
  logic [NW-1:0]    hix, hiy;

  assign magx = nx_q[NW-1] ? -nx_q : nx_q;
  assign magy = ny_q[NW-1] ? -ny_q : ny_q;
  assign extx = {{QB{1'b0}}, magx};
  assign exty = {{QB{1'b0}}, magy};
  assign hix  = extx[NW+QB-1:QB];
  assign hiy  = exty[NW+QB-1:QB];
  assign dext = {{(NW-DW){1'b0}}, d5_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o           <= d5_q;
      rem_x_o       <= hix[DW-1:0];
      rem_y_o       <= hiy[DW-1:0];
      nq_x_o        <= extx[QB-1:0];
      nq_y_o        <= exty[QB-1:0];
      flags_o.zero  <= zero_q;
      flags_o.neg_x <= nx_q[NW-1] ^ dneg_q;
      flags_o.neg_y <= ny_q[NW-1] ^ dneg_q;
      flags_o.big_x <= (hix >= dext);
      flags_o.big_y <= (hiy >= dext);
    end
  end

endmodule

@@ hw/rtl/cc_div_step.sv @@
// one restoring division step for both centre coordinates, registered
// depends on cc_pkg
`timescale 1ns / 1ps

module cc_div_step #(
  parameter int unsigned DW = 35
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [DW-1:0]            d_i,
  input  logic [DW-1:0]            rem_x_i,
  input  logic [DW-1:0]            rem_y_i,
  input  logic [cc_pkg::QBITS-1:0] nq_x_i,
  input  logic [cc_pkg::QBITS-1:0] nq_y_i,
  input  cc_pkg::flags_t           flags_i,
  output logic [DW-1:0]            d_o,
  output logic [DW-1:0]            rem_x_o,
  output logic [DW-1:0]            rem_y_o,
  output logic [cc_pkg::QBITS-1:0] nq_x_o,
  output logic [cc_pkg::QBITS-1:0] nq_y_o,
  output cc_pkg::flags_t           flags_o
);
  localparam int unsigned QB = cc_pkg::QBITS;

  logic [DW:0] sh_x, sh_y, tr_x, tr_y;
  logic        ge_x, ge_y;

  // shift in the next numerator bit and trial subtract
  assign sh_x = {rem_x_i, nq_x_i[QB-1]};
  assign sh_y = {rem_y_i, nq_y_i[QB-1]};
  assign tr_x = sh_x - {1'b0, d_i};
  assign tr_y = sh_y - {1'b0, d_i};
  assign ge_x = (sh_x >= {1'b0, d_i});
  assign ge_y = (sh_y >= {1'b0, d_i});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_o     <= d_i;
      rem_x_o <= ge_x ? tr_x[DW-1:0] : sh_x[DW-1:0];
      rem_y_o <= ge_y ? tr_y[DW-1:0] : sh_y[DW-1:0];
      nq_x_o  <= {nq_x_i[QB-2:0], ge_x};
      nq_y_o  <= {nq_y_i[QB-2:0], ge_y};
      flags_o <= flags_i;
    end
  end

endmodule

@@ hw/rtl/three_point_circumcenter_unit.sv @@
// Circumcenter of three integer points, exact integer arithmetic. One point triple is
// taken per clock unless the spare output entry is full, and each gives one centre: front
// stages of products and sums, then a 32-stage restoring divider that settles one quotient
// bit per stage for both coordinates against the shared divisor 2D, then saturation into
// the output register. Quotients truncate toward zero; collinear points give zeros with
// degenerate set, and a centre beyond the 32-bit range clamps and sets degenerate. A
// two-entry output buffer keeps the input open while one finished centre waits.
// depends on cc_pkg, cc_ifs, cc_front, cc_div_step
`timescale 1ns / 1ps

module three_point_circumcenter_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cc_pts_if.sink     pts_i,
  cc_ctr_if.source   ctr_o
);
  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned DW  = 2 * CW + 3;
  localparam int unsigned QB  = cc_pkg::QBITS;
  localparam int unsigned FS  = 6;
  localparam int unsigned NS  = FS + QB;

  logic adv;
  logic [NS-1:0] v_q;

  logic [DW-1:0]  d_s     [0:QB];
  logic [DW-1:0]  rem_x_s [0:QB];
  logic [DW-1:0]  rem_y_s [0:QB];
  logic [QB-1:0]  nq_x_s  [0:QB];
  logic [QB-1:0]  nq_y_s  [0:QB];
  cc_pkg::flags_t fl_s    [0:QB];

  // pipeline moves whenever the spare output entry is free
  logic skid_v_q;
  assign adv         = ~skid_v_q;
  assign pts_i.ready = adv;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NS-2:0], pts_i.valid};
    end
  end

  cc_front #(.CW(CW)) u_front (
    .clk_i   (clk_i),
    .en_i    (adv),
    .x1_i    (pts_i.first_x),
    .y1_i    (pts_i.first_y),
    .x2_i    (pts_i.second_x),
    .y2_i    (pts_i.second_y),
    .x3_i    (pts_i.third_x),
    .y3_i    (pts_i.third_y),
    .d_o     (d_s[0]),
    .rem_x_o (rem_x_s[0]),
    .rem_y_o (rem_y_s[0]),
    .nq_x_o  (nq_x_s[0]),
    .nq_y_o  (nq_y_s[0]),
    .flags_o (fl_s[0])
  );

  // divider stages
  for (genvar k = 0; k < QB; k++) begin : g_div
    cc_div_step #(.DW(DW)) u_step (
      .clk_i   (clk_i),
      .en_i    (adv),
      .d_i     (d_s[k]),
      .rem_x_i (rem_x_s[k]),
      .rem_y_i (rem_y_s[k]),
      .nq_x_i  (nq_x_s[k]),
      .nq_y_i  (nq_y_s[k]),
      .flags_i (fl_s[k]),
      .d_o     (d_s[k+1]),
      .rem_x_o (rem_x_s[k+1]),
      .rem_y_o (rem_y_s[k+1]),
      .nq_x_o  (nq_x_s[k+1]),
      .nq_y_o  (nq_y_s[k+1]),
      .flags_o (fl_s[k+1])
    );
  end

  // sign, clamp; top bit of the result is the saturation flag
  function automatic logic [QB:0] finish(logic [QB-1:0] q, logic neg, logic big);
    logic          over;
    logic [QB-1:0] val;
    over = big | (neg ? (q > cc_pkg::NEG_MAX) : q[QB-1]);
    if (over) begin
      val = neg ? cc_pkg::NEG_MAX : cc_pkg::POS_MAX;
    end else begin
      val = neg ? (~q + 1'b1) : q;
    end
    return {over, val};
  endfunction

  logic [QB:0]   fx, fy;
  logic [QB-1:0] res_x, res_y;
  logic          res_deg, fin_v;

  assign fx      = finish(nq_x_s[QB], fl_s[QB].neg_x, fl_s[QB].big_x);
  assign fy      = finish(nq_y_s[QB], fl_s[QB].neg_y, fl_s[QB].big_y);
  assign res_x   = fl_s[QB].zero ? '0 : fx[QB-1:0];
  assign res_y   = fl_s[QB].zero ? '0 : fy[QB-1:0];
  assign res_deg = fl_s[QB].zero | fx[QB] | fy[QB];
  assign fin_v   = v_q[NS-1] & adv;

  // output register plus spare entry
  logic          out_v_q, out_deg_q, skid_deg_q, out_take;
  logic [QB-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;

  assign out_take = out_v_q & ctr_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        out_x_q   <= skid_x_q;
        out_y_q   <= skid_y_q;
        out_deg_q <= skid_deg_q;
        skid_v_q  <= 1'b0;
      end
    end else if (fin_v) begin
      if (!out_v_q || out_take) begin
        out_x_q   <= res_x;
        out_y_q   <= res_y;
        out_deg_q <= res_deg;
        out_v_q   <= 1'b1;
      end else begin
        skid_x_q   <= res_x;
        skid_y_q   <= res_y;
        skid_deg_q <= res_deg;
        skid_v_q   <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  assign ctr_o.valid      = out_v_q;
  assign ctr_o.center_x   = out_x_q;
  assign ctr_o.center_y   = out_y_q;
  assign ctr_o.degenerate = out_deg_q;

endmodule

@@ hw/rtl/cc_checker.sv @@
// port-level checks of the circumcenter unit, bound to the top level
// depends on three_point_circumcenter_unit_macros.svh
`timescale 1ns / 1ps
`include "three_point_circumcenter_unit_macros.svh"

module cc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] center_x_i,
  input logic [31:0] center_y_i,
  input logic        degenerate_i
);

  // a stalled item holds
  `CC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(center_x_i) && $stable(center_y_i) && $stable(degenerate_i))

  // input only closes while a finished item is waiting
  `CC_ASSERT_IMP(a_full_waits, !in_ready_i, out_valid_i)

  // nothing is offered straight after reset
  `CC_ASSERT_RST(a_rst_empty, !out_valid_i)

endmodule

bind three_point_circumcenter_unit cc_checker u_cc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pts_i.valid),
  .in_ready_i   (pts_i.ready),
  .out_valid_i  (ctr_o.valid),
  .out_ready_i  (ctr_o.ready),
  .center_x_i   (ctr_o.center_x),
  .center_y_i   (ctr_o.center_y),
  .degenerate_i (ctr_o.degenerate)
);
